@@ design/quadratic_bisection_root_finder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic bisection root finder
// Implication templates used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_BISECTION_ROOT_FINDER_TOP_ASSERT_SVH
`define QUADRATIC_BISECTION_ROOT_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QBRF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QBRF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/qbrf_pkg.sv @@
// ----------------------------------------------------------------------------
// qbrf_pkg
// Types and fixed constants of the quadratic bisection root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package qbrf_pkg;

  localparam int DATA_W    = 32;
  localparam int PASS_W    = 7;
  localparam int TOL_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = DATA_W + 1;   // multiplier operand
  localparam int PROD_W    = 2 * OP_W;     // multiplier product
  localparam int ACC_W     = 97;           // exact polynomial sum, any legal scaling

  typedef enum logic [1:0] {
    ST_SMALL  = 2'd0,
    ST_ZERO   = 2'd1,
    ST_NARROW = 2'd2,
    ST_LIMIT  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SQUARE   = 3'd0,
    REG_LINEAR   = 3'd1,
    REG_CONSTANT = 3'd2,
    REG_TOL      = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_end;
    logic signed [DATA_W-1:0] right_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] root;
    logic [PASS_W-1:0]        passes;
    status_t                  status;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/quadratic_bisection_root_finder_top.sv @@
// ----------------------------------------------------------------------------
// Quadratic bisection root finder
// Bisects an input interval toward a root of a*x*x + b*x + c in signed fixed
// point, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries {left_end, right_end}. The block
//   takes one interval at a time; in_ready is high only while it is idle.
//   Result channel out_valid/out_ready carries {root, passes, status}, held
//   in an output register, so a new interval may be accepted while an older
//   result still waits for its transfer.
//   Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
//   coefficients (index 0..2) and tolerance (index 3); other indexes drop the
//   write. cfg_ready is always high; write only while the block is idle.
// Sequence:
//   Every evaluation of the polynomial runs on the shared 33x33 multiplier
//   (three products, one add, two accumulates, saturate, decide). One
//   evaluation at the left end precedes the passes, and each pass evaluates
//   the polynomial at its midpoint.
// Reset and stall:
//   Synchronous active-low reset returns to idle, drops any pending result
//   and loads the default coefficients. If a search finishes while the
//   previous result has not been taken, the sequencer holds in its decide
//   step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_bisection_root_finder_top #(
  parameter int MAX_PASSES = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire qbrf_pkg::in_item_t                  in_item,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      qbrf_pkg::out_item_t                 out_item,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [qbrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [qbrf_pkg::DATA_W-1:0]         cfg_data
);

  import qbrf_pkg::*;

  // Default register values: 0.77, -2.35, -4 and 0.015, rounded to nearest.
  localparam longint ONE_Q     = longint'(1) <<< FRAC_BITS;
  localparam longint SQ_RST    = (77 * ONE_Q + 50) / 100;
  localparam longint LIN_RST   = -((235 * ONE_Q + 50) / 100);
  localparam longint CONST_RST = -(4 * ONE_Q);
  localparam longint TOL_RST   = (15 * ONE_Q + 500) / 1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_AX,   // prod = a * x
    S_ADD_B,    // t = a * x + b * 2^F
    S_MUL_LO,   // prod = t[31:0] * x
    S_MUL_HI,   // prod = t[63:32] * x, acc = low product + c * 2^2F
    S_ACC_HI,   // acc += high product * 2^32
    S_SAT,      // floor, saturate, pick the kept half
    S_DEC       // stop test, next midpoint
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic signed [DATA_W-1:0] coef_sq_r;
  logic signed [DATA_W-1:0] coef_lin_r;
  logic signed [DATA_W-1:0] coef_const_r;
  logic [TOL_W-1:0]         tol_r;

  // Search state.
  logic signed [DATA_W-1:0] lo_r;
  logic signed [DATA_W-1:0] hi_r;
  logic signed [DATA_W-1:0] mid_r;      // evaluation point, last midpoint
  logic signed [DATA_W:0]   diff_r;     // hi - lo at the start of the pass
  logic                     narrow_r;
  logic signed [DATA_W-1:0] fm_r;
  logic                     fl_nz_r;    // f(lo) nonzero
  logic                     fl_neg_r;   // f(lo) negative
  logic                     init_r;     // evaluating f at the left end
  logic [PASS_W-1:0]        pass_cnt_r;
  logic                     out_valid_r;
  out_item_t                out_item_r;

  // Shared arithmetic unit.
  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [2*DATA_W-1:0] t_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [2*DATA_W-1:0] lin_shift;
  logic signed [ACC_W-1:0]  const_shift;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_sh;
  logic                     sat_ok;
  logic signed [DATA_W-1:0] fm_sat;
  logic                     fm_nz;
  logic                     fm_neg;
  logic                     go_hi;

  logic signed [DATA_W:0]   sum_lh;
  logic signed [DATA_W:0]   diff_lh;
  logic [DATA_W:0]          diff_abs;
  logic [DATA_W-1:0]        fm_abs;
  logic                     fm_small;
  logic                     last_pass;
  logic                     stop;
  status_t                  stop_status;
  logic                     res_load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration writes; unknown indexes drop the write.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_sq_r    <= DATA_W'(SQ_RST);
      coef_lin_r   <= DATA_W'(LIN_RST);
      coef_const_r <= DATA_W'(CONST_RST);
      tol_r        <= TOL_W'(TOL_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SQUARE:   coef_sq_r    <= cfg_data;
        REG_LINEAR:   coef_lin_r   <= cfg_data;
        REG_CONSTANT: coef_const_r <= cfg_data;
        REG_TOL:      tol_r        <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Multiplier operand select. Horner form: f = ((a*x + b*2^F) * x) + c*2^2F,
  // the 64-bit middle term split in two 32-bit halves for the second product.
  // --------------------------------------------------------------------------
  always_comb begin
    op_b = {mid_r[DATA_W-1], mid_r};
    unique case (state_r)
      S_MUL_LO: op_a = {1'b0, t_r[DATA_W-1:0]};
      S_MUL_HI: op_a = {t_r[2*DATA_W-1], t_r[2*DATA_W-1:DATA_W]};
      default:  op_a = {coef_sq_r[DATA_W-1], coef_sq_r};
    endcase
  end

  assign mul_p = op_a * op_b;

  assign lin_shift   = {{DATA_W{coef_lin_r[DATA_W-1]}}, coef_lin_r} <<< FRAC_BITS;
  assign const_shift = {{(ACC_W-DATA_W){coef_const_r[DATA_W-1]}}, coef_const_r}
                       <<< (2 * FRAC_BITS);
  assign prod_ext    = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_MUL_AX: prod_r <= mul_p;
      S_ADD_B:  t_r    <= prod_r[2*DATA_W-1:0] + lin_shift;
      S_MUL_LO: prod_r <= mul_p;
      S_MUL_HI: begin
        prod_r <= mul_p;
        acc_r  <= prod_ext + const_shift;
      end
      S_ACC_HI: acc_r <= acc_r + (prod_ext <<< DATA_W);
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Floor to the fixed-point grid and saturate to 32 bits; the sign of the
  // exact sum is the sign of the saturated value.
  // --------------------------------------------------------------------------
  assign acc_sh = acc_r >>> (2 * FRAC_BITS);
  assign sat_ok = (&acc_sh[ACC_W-1:DATA_W-1]) | ~(|acc_sh[ACC_W-1:DATA_W-1]);
  assign fm_sat = sat_ok ? acc_sh[DATA_W-1:0]
                : (acc_r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}});
  assign fm_nz  = |acc_sh;
  assign fm_neg = acc_r[ACC_W-1];

  // Keep the left half only when f(lo) and f(mid) have strictly opposite signs.
  assign go_hi = fl_nz_r && (fl_neg_r != fm_neg);

  // Next midpoint (floor) and width from the updated interval.
  assign sum_lh   = {lo_r[DATA_W-1], lo_r} + {hi_r[DATA_W-1], hi_r};
  assign diff_lh  = {hi_r[DATA_W-1], hi_r} - {lo_r[DATA_W-1], lo_r};
  assign diff_abs = diff_r[DATA_W] ? (~diff_r + 1'b1) : diff_r;

  assign fm_abs    = fm_r[DATA_W-1] ? (~fm_r + 1'b1) : fm_r;
  assign fm_small  = (fm_abs <= {1'b0, tol_r});
  assign last_pass = (pass_cnt_r == PASS_W'(MAX_PASSES));

  always_comb begin
    stop        = 1'b1;
    stop_status = ST_LIMIT;
    priority if (fm_r == '0) begin
      stop_status = ST_ZERO;
    end else if (narrow_r) begin
      stop_status = ST_NARROW;
    end else if (fm_small) begin
      stop_status = ST_SMALL;
    end else if (last_pass) begin
      stop_status = ST_LIMIT;
    end else begin
      stop = 1'b0;
    end
  end

  // A finished search moves into the output register once it is free.
  assign res_load = (state_r == S_DEC) && !init_r && stop && (!out_valid_r || out_ready);

  // --------------------------------------------------------------------------
  // Sequencer, search state and result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      init_r      <= 1'b0;
      pass_cnt_r  <= '0;
    end else begin
      // Load a finished search, else let a result transfer free the register.
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            lo_r    <= in_item.left_end;
            hi_r    <= in_item.right_end;
            mid_r   <= in_item.left_end;
            init_r  <= 1'b1;
            state_r <= S_MUL_AX;
          end
        end
        S_MUL_AX: begin
          narrow_r <= (diff_abs < {2'b00, tol_r});
          state_r  <= S_ADD_B;
        end
        S_ADD_B:  state_r <= S_MUL_LO;
        S_MUL_LO: state_r <= S_MUL_HI;
        S_MUL_HI: state_r <= S_ACC_HI;
        S_ACC_HI: state_r <= S_SAT;
        S_SAT: begin
          fm_r <= fm_sat;
          if (init_r) begin
            fl_nz_r  <= fm_nz;
            fl_neg_r <= fm_neg;
          end else if (go_hi) begin
            hi_r <= mid_r;
          end else begin
            // Moving lo onto mid carries f(mid) over as the new f(lo).
            lo_r     <= mid_r;
            fl_nz_r  <= fm_nz;
            fl_neg_r <= fm_neg;
          end
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (init_r || !stop) begin
            mid_r      <= sum_lh[DATA_W:1];
            diff_r     <= diff_lh;
            pass_cnt_r <= init_r ? PASS_W'(1) : pass_cnt_r + 1'b1;
            init_r     <= 1'b0;
            state_r    <= S_MUL_AX;
          end else if (res_load) begin
            out_item_r.root   <= mid_r;
            out_item_r.passes <= pass_cnt_r;
            out_item_r.status <= stop_status;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/qbrf_checker.sv @@
// ----------------------------------------------------------------------------
// qbrf_checker
// Port-level checks of the quadratic bisection root finder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_bisection_root_finder_top_assert.svh"

module qbrf_checker #(
  parameter int MAX_PASSES = 64
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire qbrf_pkg::out_item_t out_item
);

  import qbrf_pkg::*;

  // A stalled result holds until its transfer.
  `QBRF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

  // Pass count stays within one and the limit.
  `QBRF_ASSERT_NOW(a_pass_range, clk, rst_n, out_valid, (out_item.passes != '0) && (out_item.passes <= PASS_W'(MAX_PASSES)), "pass count out of range")

  // A pass-limit stop only after the last allowed pass.
  `QBRF_ASSERT_NOW(a_limit_cnt, clk, rst_n, out_valid && (out_item.status == ST_LIMIT), out_item.passes == PASS_W'(MAX_PASSES), "pass limit reported early")

  // One interval at a time: busy right after an input transfer.
  `QBRF_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while searching")

endmodule

bind quadratic_bisection_root_finder_top qbrf_checker #(
  .MAX_PASSES (MAX_PASSES)
) u_qbrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic bisection root finder testbench
// Streams search intervals through the block under several coefficient and
// tolerance settings, predicts each root, pass count and status with an
// exact wide-integer bisection, and checks every result in order.
// ----------------------------------------------------------------------------

module testbench;
  import qbrf_pkg::*;

  localparam int MAX_PASSES = 64;
  localparam int FRAC_BITS  = 16;
  localparam int Q_ONE      = 1 << FRAC_BITS;

  // Power-up register values: 0.77, -2.35, -4.0 and 0.015.
  localparam logic signed [31:0] DEF_SQUARE   = 32'sd50463;
  localparam logic signed [31:0] DEF_LINEAR   = -32'sd154010;
  localparam logic signed [31:0] DEF_CONSTANT = -32'sd262144;
  localparam logic [30:0]        DEF_TOL      = 31'd983;

  // Indexes outside the register map; the block drops these writes.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AT      = 40;
  localparam int DRAIN_CYCLES = 7 * (MAX_PASSES + 1) + 32;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic signed [127:0] F_MAX = (128'sd1 <<< 31) - 128'sd1;
  localparam logic signed [127:0] F_MIN = -(128'sd1 <<< 31);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  // Predictor copy of the register file.
  logic signed [31:0] sq_coef  = DEF_SQUARE;
  logic signed [31:0] lin_coef = DEF_LINEAR;
  logic signed [31:0] cst_coef = DEF_CONSTANT;
  logic [30:0]        tol_reg  = DEF_TOL;

  // Approximate roots of the current quadratic, used to aim intervals.
  real root_a = 0.0;
  real root_b = 0.0;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int intervals_sent = 0;
  int results_seen = 0;
  int settings_used = 1;
  int status_seen[4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  quadratic_bisection_root_finder_top #(
    .MAX_PASSES(MAX_PASSES),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Evaluate the quadratic exactly at 128 bits, floor the fraction away and
  // clamp to the 32-bit range.
  function automatic logic signed [31:0] poly_at(input logic signed [31:0] x);
    logic signed [127:0] xs, a, b, c, acc;
    xs  = x;
    a   = sq_coef;
    b   = lin_coef;
    c   = cst_coef;
    acc = a * xs * xs + ((b * xs) <<< FRAC_BITS) + (c <<< (2 * FRAC_BITS));
    acc = acc >>> (2 * FRAC_BITS);
    if (acc > F_MAX) return 32'sh7FFF_FFFF;
    if (acc < F_MIN) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  // Run the bisection for one interval and return the result it produces.
  function automatic out_item_t find_root(input in_item_t item);
    logic signed [63:0] lo, hi, mid, width, fm, fl, tol;
    out_item_t res;
    bit done;
    int n;
    lo   = item.left_end;
    hi   = item.right_end;
    mid  = 0;
    tol  = {33'b0, tol_reg};
    done = 1'b0;
    res.status = ST_LIMIT;
    res.passes = '0;
    for (n = 1; n <= MAX_PASSES && !done; n++) begin
      // Arithmetic shift floors the midpoint toward minus infinity.
      mid = (lo + hi) >>> 1;
      fm  = poly_at(mid[31:0]);
      width = hi - lo;
      if (width < 0) width = -width;
      res.passes = n[PASS_W-1:0];
      if (fm == 0) begin
        res.status = ST_ZERO;
        done = 1'b1;
      end else if (width < tol) begin
        res.status = ST_NARROW;
        done = 1'b1;
      end else begin
        fl = poly_at(lo[31:0]);
        // Keep the left half only on a strict sign change.
        if (fl != 0 && ((fl < 0) != (fm < 0))) hi = mid;
        else lo = mid;
        if ((fm < 0 ? -fm : fm) <= tol) begin
          res.status = ST_SMALL;
          done = 1'b1;
        end
      end
    end
    res.root = mid[31:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] to_q16(input real v);
    if (v > 32767.0) v = 32767.0;
    if (v < -32767.0) v = -32767.0;
    return $rtoi(v * 65536.0);
  endfunction

  function automatic in_item_t interval(input logic signed [31:0] l,
                                        input logic signed [31:0] r);
    in_item_t item;
    item.left_end  = l;
    item.right_end = r;
    return item;
  endfunction

  // Mostly intervals around a root of the current quadratic, the rest
  // full-range noise, near-empty intervals and moderate random spans.
  function automatic in_item_t random_interval();
    longint ctr, lo, hi, tmp;
    int pick, sh;
    pick = $urandom_range(99);
    if (pick < 60) begin
      ctr = to_q16($urandom_range(1) ? root_a : root_b);
      sh  = $urandom_range(22);
      lo  = ctr - longint'($urandom_range(1 << sh));
      sh  = $urandom_range(22);
      hi  = ctr + longint'($urandom_range(1 << sh));
      if ($urandom_range(4) == 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
    end else if (pick < 72) begin
      lo = longint'($signed($urandom));
      hi = longint'($signed($urandom));
    end else if (pick < 84) begin
      lo = longint'($signed($urandom));
      hi = lo + longint'($urandom_range(1023)) - 512;
    end else begin
      lo = longint'($urandom_range(1 << 23)) - (1 << 22);
      hi = longint'($urandom_range(1 << 23)) - (1 << 22);
    end
    return interval(sat32(lo), sat32(hi));
  endfunction

  // Write one register and mirror the write in the predictor at the transfer.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SQUARE:   sq_coef  = data;
      REG_LINEAR:   lin_coef = data;
      REG_CONSTANT: cst_coef = data;
      REG_TOL:      tol_reg  = data[30:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Load a full setting, then refresh the root estimates used for aiming.
  task automatic set_quadratic(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] tol);
    real ra, rb, rc, disc;
    write_reg(REG_SQUARE, a);
    write_reg(REG_LINEAR, b);
    write_reg(REG_CONSTANT, c);
    write_reg(REG_TOL, tol);
    settings_used++;
    ra = $itor(sq_coef) / 65536.0;
    rb = $itor(lin_coef) / 65536.0;
    rc = $itor(cst_coef) / 65536.0;
    if (sq_coef == 0) begin
      root_a = (lin_coef != 0) ? -rc / rb : 0.0;
      root_b = root_a;
    end else begin
      disc = rb * rb - 4.0 * ra * rc;
      if (disc < 0.0) disc = 0.0;
      root_a = (-rb + $sqrt(disc)) / (2.0 * ra);
      root_b = (-rb - $sqrt(disc)) / (2.0 * ra);
    end
  endtask

  // Quadratic with random real roots in [-50, 50] and a random scale.
  task automatic set_random_roots(input logic [31:0] tol);
    real r1, r2, a;
    r1 = ($itor($urandom_range(100000)) - 50000.0) / 1000.0;
    r2 = ($itor($urandom_range(100000)) - 50000.0) / 1000.0;
    a  = $itor($urandom_range(4000) + 10) / 1000.0;
    if ($urandom_range(1)) a = -a;
    set_quadratic(to_q16(a), to_q16(-a * (r1 + r2)), to_q16(a * r1 * r2), tol);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_q.push_back(random_interval());
  endtask

  // Hold until every queued interval has gone in and every result came out.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offer pending intervals, predict each one at its transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(find_root(in_item));
        intervals_sent++;
      end
      // Hold the payload while the block stalls; otherwise advance or idle.
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_item  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: root %0d passes %0d status %0d",
                   $realtime, out_item.root, out_item.passes, out_item.status);
        end else begin
          want = expected_q.pop_front();
          status_seen[int'(want.status)]++;
          if (out_item.root !== want.root) begin
            mismatches++;
            $display("%0t: root mismatch: expected %0d, actual %0d",
                     $realtime, want.root, out_item.root);
          end
          if (out_item.passes !== want.passes) begin
            mismatches++;
            $display("%0t: passes mismatch: expected %0d, actual %0d",
                     $realtime, want.passes, out_item.passes);
          end
          if (out_item.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $realtime, want.status, out_item.status);
          end
        end
        results_seen <= results_seen + 1;
      end
      // Drop ready during the long hold-off and on random idle cycles.
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // Long receiver hold-off, started once partway through the first phase,
  // so the output register and the sequencer back up and stall the input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Power-up setting: sender idles rarely, receiver often.
    send_idle = 7;
    recv_idle = 82;
    root_a = 4.269;
    root_b = -1.217;
    pending_q.push_back(interval(32'sh8000_0000, 32'sh7FFF_FFFF));  // full range
    pending_q.push_back(interval(32'sh7FFF_FFFF, 32'sh8000_0000));  // reversed ends
    pending_q.push_back(interval(0, 0));                            // empty width
    pending_q.push_back(interval(32'sh8000_0000, 32'sh8000_0000));
    pending_q.push_back(interval(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_q.push_back(interval(0, 10 * Q_ONE));                   // brackets a root
    pending_q.push_back(interval(-5 * Q_ONE, 0));                   // the other root
    pending_q.push_back(interval(10 * Q_ONE, 0));                   // reversed bracket
    pending_q.push_back(interval(5 * Q_ONE, 10 * Q_ONE));           // no sign change
    pending_q.push_back(interval(-3, 0));                           // odd negative sum
    pending_q.push_back(interval(-1, 0));
    pending_q.push_back(interval(Q_ONE, 32'sh7FFF_FFFF));           // f saturates
    queue_random(100);
    wait_drained();

    // x*x - 4 hits zero exactly at +-2.0.
    set_quadratic(Q_ONE, 0, -4 * Q_ONE, DEF_TOL);
    pending_q.push_back(interval(0, 4 * Q_ONE));
    pending_q.push_back(interval(-4 * Q_ONE, 0));
    wait_drained();

    // 3x + one LSB never reaches zero; zero tolerance runs to the pass limit.
    set_quadratic(0, 3 * Q_ONE, 1, 0);
    write_reg(REG_SPARE_LO, 32'hDEAD_BEEF);
    write_reg(REG_SPARE_HI, 32'h0000_0001);
    pending_q.push_back(interval(-Q_ONE, Q_ONE));
    pending_q.push_back(interval(0, 100));
    pending_q.push_back(interval(32'sh8000_0000, 32'sh7FFF_FFFF));
    wait_drained();

    set_random_roots($urandom_range(4000));
    queue_random(110);
    wait_drained();

    // Extremes: receiver idles rarely, sender often.
    send_idle = 82;
    recv_idle = 7;
    set_quadratic(32'h7FFF_FFFF, 32'h8000_0000, $urandom, 0);
    queue_random(100);
    wait_drained();

    // Largest tolerance, written with bit 31 set to show it is dropped.
    set_quadratic(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_random(100);
    wait_drained();

    // No idling from here on.
    send_idle = 0;
    recv_idle = 0;
    set_random_roots($urandom_range(200));
    queue_random(120);
    wait_drained();

    set_quadratic(0, $urandom, $urandom, $urandom_range(Q_ONE));
    queue_random(120);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Bisected %0d intervals under %0d register settings; %0d results compared.",
             intervals_sent, settings_used, results_seen);
    $display("Statuses seen: small residual %0d, exact zero %0d, narrow %0d, pass limit %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (expected_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $realtime, expected_q.size());
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
